### rtl/poly_hash_gf2_64_top_defines.svh
// assertion macros used by the checker
`ifndef POLY_HASH_GF2_64_TOP_DEFINES_SVH
`define POLY_HASH_GF2_64_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PHG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PHG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/phg_pkg.sv
package phg_pkg;

	localparam int KEY_W             = 64;
	localparam int HALF_W            = KEY_W / 2;
	localparam int TC_W              = 3;
	localparam int CFG_IDX_W         = 4;
	localparam int DEFAULT_MAX_TERMS = 7;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE  = 4'd1;

	localparam logic [TC_W-1:0] TC_RESET = 3'd2;

	// reduction shifts for x^64 + x^4 + x^3 + x + 1
	localparam int RED_HI_A = 60;
	localparam int RED_HI_B = 61;
	localparam int RED_HI_C = 63;
	localparam int RED_LO_A = 1;
	localparam int RED_LO_B = 3;
	localparam int RED_LO_C = 4;

	// word handed from one cell to the next
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] acc;
	} stage_t;

	// carry-less 32x32 product
	function automatic logic [KEY_W-1:0] clmul32(input logic [HALF_W-1:0] a,
			input logic [HALF_W-1:0] b);
		logic [KEY_W-1:0] r;
		r = '0;
		for (int i = 0; i < HALF_W; i++) begin
			if (b[i]) begin
				r = r ^ ({{HALF_W{1'b0}}, a} << i);
			end
		end
		return r;
	endfunction

	// full reduction of a 128-bit carry-less product
	function automatic logic [KEY_W-1:0] gf_reduce(input logic [KEY_W-1:0] hi,
			input logic [KEY_W-1:0] lo);
		logic [KEY_W-1:0] m;
		m = hi ^ (hi >> RED_HI_A) ^ (hi >> RED_HI_B) ^ (hi >> RED_HI_C);
		return m ^ (m << RED_LO_A) ^ (m << RED_LO_B) ^ (m << RED_LO_C) ^ lo;
	endfunction

endpackage

### rtl/poly_hash_gf2_64_top.sv
// GF(2^64) polynomial hash, field polynomial x^64+x^4+x^3+x+1. Each key is the
// evaluation point of the polynomial coef_0*x^(k-1) + ... + coef_(k-1), k set
// by term_count (0 counts as 1, values above MAX_TERMS saturate), evaluated by
// Horner's rule. One key is accepted per cycle unless in_stall is high. The
// latency is the same whatever term_count is: the chain has MAX_TERMS-1
// Horner cells of two stages each (partial products, then reduce and add),
// unused cells pass the value through, and an output register follows. Stall
// backs up stage by stage, so bubbles are squeezed out before the input stalls.
// Configuration writes are taken every cycle and must only happen while no
// key is in flight.
module poly_hash_gf2_64_top
	import phg_pkg::*;
#(
	parameter int MAX_TERMS = DEFAULT_MAX_TERMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [KEY_W-1:0]     key,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [KEY_W-1:0]     hash_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data
);

	localparam int N_CELLS = MAX_TERMS - 1;

	logic [TC_W-1:0]  term_eff;
	logic [KEY_W-1:0] coef [MAX_TERMS];
	stage_t           link [N_CELLS+1];
	logic             link_ready [N_CELLS+1];
	logic             out_valid_q;
	logic [KEY_W-1:0] hash_q;
	logic             ready_out;

	assign cfg_ready = 1'b1;

	phg_cfg #(
		.MAX_TERMS(MAX_TERMS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.term_eff (term_eff),
		.coef     (coef)
	);

	// chain entry: leading coefficient is the Horner start value
	assign link[0]  = '{valid: in_valid, key: key, acc: coef[0]};
	assign in_stall = !link_ready[0];

	// Horner cells, cell g+1 adds coef g+1
	for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
		phg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_stage (link[g]),
			.in_ready (link_ready[g]),
			.active   (term_eff > TC_W'(g + 1)),
			.coef     (coef[g+1]),
			.out_stage(link[g+1]),
			.out_ready(link_ready[g+1])
		);
	end

	// output register
	assign ready_out           = !out_valid_q || !out_stall;
	assign link_ready[N_CELLS] = ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= link[N_CELLS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && link[N_CELLS].valid) begin
			hash_q <= link[N_CELLS].acc;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule

### rtl/phg_cell.sv
module phg_cell
	import phg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  stage_t           in_stage,
	output logic             in_ready,
	input  logic             active,
	input  logic [KEY_W-1:0] coef,
	output stage_t           out_stage,
	input  logic             out_ready
);

	logic             v_s1;
	logic [KEY_W-1:0] key_s1;
	logic [KEY_W-1:0] acc_s1;
	logic [KEY_W-1:0] pp_ll_s1;
	logic [KEY_W-1:0] pp_mid_s1;
	logic [KEY_W-1:0] pp_hh_s1;
	logic             v_s2;
	logic [KEY_W-1:0] key_s2;
	logic [KEY_W-1:0] acc_s2;
	logic             ready_s1;
	logic             ready_s2;
	logic [KEY_W-1:0] prod_hi;
	logic [KEY_W-1:0] prod_lo;
	logic [KEY_W-1:0] step_res;

	// per-stage flow control, a stage moves when empty or draining
	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_stage.valid;
		end
	end

	// stage 1: four 32x32 carry-less partial products
	always_ff @(posedge clk) begin
		if (ready_s1 && in_stage.valid) begin
			key_s1    <= in_stage.key;
			acc_s1    <= in_stage.acc;
			pp_ll_s1  <= clmul32(in_stage.acc[HALF_W-1:0], in_stage.key[HALF_W-1:0]);
			pp_mid_s1 <= clmul32(in_stage.acc[HALF_W-1:0], in_stage.key[KEY_W-1:HALF_W])
				^ clmul32(in_stage.acc[KEY_W-1:HALF_W], in_stage.key[HALF_W-1:0]);
			pp_hh_s1  <= clmul32(in_stage.acc[KEY_W-1:HALF_W],
				in_stage.key[KEY_W-1:HALF_W]);
		end
	end

	// combine partials, reduce, add the coefficient; idle cells pass through
	always_comb begin
		prod_lo  = pp_ll_s1 ^ {pp_mid_s1[HALF_W-1:0], {HALF_W{1'b0}}};
		prod_hi  = pp_hh_s1 ^ {{HALF_W{1'b0}}, pp_mid_s1[KEY_W-1:HALF_W]};
		step_res = active ? (gf_reduce(prod_hi, prod_lo) ^ coef) : acc_s1;
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			key_s2 <= key_s1;
			acc_s2 <= step_res;
		end
	end

	assign out_stage = '{valid: v_s2, key: key_s2, acc: acc_s2};

endmodule

### rtl/phg_cfg.sv
module phg_cfg
	import phg_pkg::*;
#(
	parameter int MAX_TERMS = DEFAULT_MAX_TERMS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_data,
	output logic [TC_W-1:0]      term_eff,
	output logic [KEY_W-1:0]     coef [MAX_TERMS]
);

	localparam int              COEF_IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [TC_W-1:0] MAX_N   = TC_W'(MAX_TERMS);
	localparam logic [CFG_IDX_W-1:0] COEF_END = CFG_IDX_W'(MAX_TERMS) + REG_COEF_BASE;

	logic [TC_W-1:0]      term_count_q;
	logic [KEY_W-1:0]     coef_q [MAX_TERMS];
	logic [CFG_IDX_W-1:0] coef_off;
	logic                 coef_hit;

	assign coef_off = cfg_index - REG_COEF_BASE;
	assign coef_hit = (cfg_index >= REG_COEF_BASE) && (cfg_index < COEF_END);

	// register writes; indexes past the stored coefficients are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TC_RESET;
			for (int i = 0; i < MAX_TERMS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_TERM_COUNT) begin
				term_count_q <= cfg_data[TC_W-1:0];
			end else if (coef_hit) begin
				coef_q[coef_off[COEF_IW-1:0]] <= cfg_data;
			end
		end
	end

	// zero terms means one, more than the chain holds saturates
	always_comb begin
		if (term_count_q == '0) begin
			term_eff = TC_W'(1);
		end else if (term_count_q > MAX_N) begin
			term_eff = MAX_N;
		end else begin
			term_eff = term_count_q;
		end
	end

	assign coef = coef_q;

endmodule

### rtl/phg_checker.sv
`include "poly_hash_gf2_64_top_defines.svh"

module phg_checker
	import phg_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [KEY_W-1:0]     hash_value,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic out_held;

	// result offered but held up by the receiver
	assign out_held = out_valid && out_stall;

	// a stalled result stays offered
	`PHG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid, "stalled result dropped")

	// a stalled result keeps its value
	`PHG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_held, $stable(hash_value), "stalled result changed")

	// input backpressure only when a finished result is held up
	`PHG_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_held, "input stalled with free output")

	// configuration writes are never refused
	`PHG_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind poly_hash_gf2_64_top phg_checker u_phg_checker (.*);
